// ----- src/rsfd_pkg.sv -----
// Shared types and constants of the servo frame decoder.
package rsfd_pkg;

    // Frame header bytes, the check byte the quirk accepts, and the first data position
    localparam logic [7:0] START_BYTE  = 8'hA8;
    localparam logic [7:0] SECOND_BYTE = 8'h00;
    localparam logic [7:0] QUIRK_CHECK = 8'h0A;
    localparam int         FIRST_DATA  = 3;

    // Scaling: pct = round(OUT_SPAN * (raw - RAW_MIN) / RAW_SPAN) - OUT_OFFSET
    localparam int RAW_MIN    = 7172;
    localparam int RAW_SPAN   = 9563;
    localparam int OUT_SPAN   = 3000;
    localparam int OUT_OFFSET = 1500;
    // Whole spans added so the rounded numerator never goes negative
    localparam int GUARD      = 2250;
    // Half of the biased, doubled numerator: m = OUT_SPAN * raw + SCALE_BIAS
    localparam int SCALE_BIAS = (RAW_SPAN - 2 * OUT_SPAN * RAW_MIN + 2 * GUARD * RAW_SPAN) / 2;
    localparam int PCT_OFFSET = GUARD + OUT_OFFSET;

    // Widths of the scaling datapath
    localparam int RAW_W   = 16;
    localparam int M_W     = 28;
    localparam int RECIP_W = 27;
    localparam int PROD_W  = M_W + RECIP_W;
    localparam int RECIP_SHIFT = 40;
    localparam int Q_W     = PROD_W - RECIP_SHIFT;
    localparam int BACK_W  = M_W + 1;

    // floor(2^RECIP_SHIFT / RAW_SPAN); the quotient it yields is low by at most one
    localparam logic [RECIP_W-1:0] SCALE_RECIP =
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(RAW_SPAN));

    typedef enum logic [2:0] {
        ST_RX,
        ST_READ,
        ST_SCALE,
        ST_RECIP,
        ST_CORR,
        ST_LOAD,
        ST_SEND
    } ctrl_state_t;

    typedef struct packed {
        logic byte_en;
        logic chan_clr;
        logic chan_inc;
        logic rd_en;
        logic scale_en;
        logic recip_en;
        logic corr_en;
        logic load_chan;
        logic load_err;
    } dp_cmd_t;

    typedef struct packed {
        logic at_check;
        logic check_ok;
        logic out_last;
    } dp_status_t;

endpackage

// ----- src/rsfd_if.sv -----
// Request channel interfaces: received bytes in, channel results out.
interface rsfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rsfd_out_if;
    logic               valid;
    logic               ready;
    logic               status;
    logic [3:0]         channel_index;
    logic [15:0]        raw_value;
    logic signed [15:0] percent_tenths;
    logic               last;

    modport source (output valid, output status, output channel_index, output raw_value,
                    output percent_tenths, output last, input ready);
    modport sink   (input valid, input status, input channel_index, input raw_value,
                    input percent_tenths, input last, output ready);
endinterface

// ----- src/rsfd_ctrl.sv -----
// Sequencer of the frame decoder: byte intake and per-channel result steps.
module rsfd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  rsfd_pkg::dp_status_t status,
    output rsfd_pkg::dp_cmd_t    cmd
);

    rsfd_pkg::ctrl_state_t state_reg;
    rsfd_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rsfd_pkg::ST_RX;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            rsfd_pkg::ST_RX:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.byte_en = 1'b1;
                    if (status.at_check)
                    begin
                        if (status.check_ok)
                        begin
                            cmd.chan_clr = 1'b1;
                            state_next   = rsfd_pkg::ST_READ;
                        end
                        else
                        begin
                            cmd.load_err = 1'b1;
                            state_next   = rsfd_pkg::ST_SEND;
                        end
                    end
                end
            end
            rsfd_pkg::ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = rsfd_pkg::ST_SCALE;
            end
            rsfd_pkg::ST_SCALE:
            begin
                cmd.scale_en = 1'b1;
                state_next   = rsfd_pkg::ST_RECIP;
            end
            rsfd_pkg::ST_RECIP:
            begin
                cmd.recip_en = 1'b1;
                state_next   = rsfd_pkg::ST_CORR;
            end
            rsfd_pkg::ST_CORR:
            begin
                cmd.corr_en = 1'b1;
                state_next  = rsfd_pkg::ST_LOAD;
            end
            rsfd_pkg::ST_LOAD:
            begin
                cmd.load_chan = 1'b1;
                state_next    = rsfd_pkg::ST_SEND;
            end
            rsfd_pkg::ST_SEND:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (status.out_last)
                    begin
                        state_next = rsfd_pkg::ST_RX;
                    end
                    else
                    begin
                        cmd.chan_inc = 1'b1;
                        state_next   = rsfd_pkg::ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = rsfd_pkg::ST_RX;
            end
        endcase
    end

endmodule

// ----- src/rsfd_datapath.sv -----
// Frame parsing, checksum, channel store and percent scaling datapath.
module rsfd_datapath #(
    parameter int CHANNELS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    input  logic [7:0]           rx_byte,
    input  rsfd_pkg::dp_cmd_t    cmd,
    output rsfd_pkg::dp_status_t status,
    output logic                 out_status,
    output logic [3:0]           out_channel_index,
    output logic [15:0]          out_raw_value,
    output logic signed [15:0]   out_percent_tenths,
    output logic                 out_last
);

    localparam int CW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int EXTRA_POS = rsfd_pkg::FIRST_DATA + 2 * CHANNELS;
    localparam int CHECK_POS = EXTRA_POS + 1;
    localparam int PW        = $clog2(CHECK_POS + 1);

    logic                     quirk_reg;
    logic [PW-1:0]            pos_reg;
    logic [PW-1:0]            pos_next;
    logic [7:0]               sum_reg;
    logic [7:0]               sum_next;
    logic [7:0]               hold_reg;
    logic [7:0]               hold_next;
    logic [PW-1:0]            data_k;
    logic                     store_we;
    logic [CW-1:0]            chan_reg;
    logic [CW-1:0]            chan_next;
    logic [15:0]              store_mem [CHANNELS];

    logic [rsfd_pkg::RAW_W-1:0]   raw_reg;
    logic [rsfd_pkg::M_W-1:0]     m_reg;
    logic [rsfd_pkg::PROD_W-1:0]  prod_reg;
    logic [rsfd_pkg::Q_W-1:0]     q0_reg;
    logic [rsfd_pkg::Q_W-1:0]     q0_next;
    logic [rsfd_pkg::BACK_W-1:0]  back_reg;
    logic [rsfd_pkg::BACK_W-1:0]  rem;
    logic                         q_fix;
    logic [15:0]                  pct_next;

    assign status.at_check = (pos_reg == PW'(CHECK_POS));
    assign status.check_ok = (sum_reg == rx_byte) ||
                             (quirk_reg && (rx_byte == rsfd_pkg::QUIRK_CHECK));
    assign status.out_last = out_last;

    assign data_k = pos_reg - PW'(rsfd_pkg::FIRST_DATA);

    // Frame position walk
    always_comb
    begin
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        hold_next = hold_reg;
        store_we  = 1'b0;
        if (pos_reg == '0)
        begin
            if (rx_byte == rsfd_pkg::START_BYTE)
            begin
                sum_next = rx_byte;
                pos_next = PW'(1);
            end
        end
        else if (pos_reg == PW'(1) || pos_reg == PW'(2))
        begin
            if ((pos_reg == PW'(1) && rx_byte != rsfd_pkg::SECOND_BYTE) ||
                (pos_reg == PW'(2) && rx_byte != 8'(CHANNELS)))
            begin
                pos_next = '0;
            end
            else
            begin
                sum_next = sum_reg + rx_byte;
                pos_next = pos_reg + PW'(1);
            end
        end
        else if (pos_reg < PW'(CHECK_POS))
        begin
            if (pos_reg < PW'(EXTRA_POS))
            begin
                if (!data_k[0])
                begin
                    hold_next = rx_byte;
                end
                else
                begin
                    store_we = 1'b1;
                end
            end
            sum_next = sum_reg + rx_byte;
            pos_next = pos_reg + PW'(1);
        end
        else
        begin
            pos_next = '0;
        end
    end

    always_comb
    begin
        chan_next = chan_reg;
        if (cmd.chan_clr)
        begin
            chan_next = '0;
        end
        else if (cmd.chan_inc)
        begin
            chan_next = chan_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quirk_reg <= 1'b1;
            pos_reg   <= '0;
            sum_reg   <= '0;
            hold_reg  <= '0;
            chan_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                quirk_reg <= cfg_wr_data;
            end
            if (cmd.byte_en)
            begin
                pos_reg  <= pos_next;
                sum_reg  <= sum_next;
                hold_reg <= hold_next;
            end
            chan_reg <= chan_next;
        end
    end

    // Channel store: written on the low byte, read once per result
    always_ff @(posedge clk)
    begin
        if (cmd.byte_en && store_we)
        begin
            store_mem[data_k[CW:1]] <= {hold_reg, rx_byte};
        end
        if (cmd.rd_en)
        begin
            raw_reg <= store_mem[chan_reg];
        end
    end

    // Scaling: q = floor(m / RAW_SPAN) by reciprocal, then one correction step
    assign q0_next  = prod_reg[rsfd_pkg::PROD_W-1:rsfd_pkg::RECIP_SHIFT];
    assign rem      = rsfd_pkg::BACK_W'(m_reg) - back_reg;
    assign q_fix    = (rem >= rsfd_pkg::BACK_W'(rsfd_pkg::RAW_SPAN));
    assign pct_next = 16'(q0_reg) + 16'(q_fix) - 16'(rsfd_pkg::PCT_OFFSET);

    always_ff @(posedge clk)
    begin
        if (cmd.scale_en)
        begin
            m_reg <= rsfd_pkg::M_W'(raw_reg) * rsfd_pkg::M_W'(rsfd_pkg::OUT_SPAN)
                     + rsfd_pkg::M_W'(rsfd_pkg::SCALE_BIAS);
        end
        if (cmd.recip_en)
        begin
            prod_reg <= rsfd_pkg::PROD_W'(m_reg) * rsfd_pkg::PROD_W'(rsfd_pkg::SCALE_RECIP);
        end
        if (cmd.corr_en)
        begin
            q0_reg   <= q0_next;
            back_reg <= rsfd_pkg::BACK_W'(q0_next) * rsfd_pkg::BACK_W'(rsfd_pkg::RAW_SPAN);
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_last <= 1'b0;
        end
        else if (cmd.load_err)
        begin
            out_last <= 1'b1;
        end
        else if (cmd.load_chan)
        begin
            out_last <= (chan_reg == CW'(CHANNELS - 1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_err)
        begin
            out_status         <= 1'b1;
            out_channel_index  <= '0;
            out_raw_value      <= '0;
            out_percent_tenths <= '0;
        end
        else if (cmd.load_chan)
        begin
            out_status         <= 1'b0;
            out_channel_index  <= 4'(chan_reg) + 4'd1;
            out_raw_value      <= raw_reg;
            out_percent_tenths <= $signed(pct_next);
        end
    end

endmodule

// ----- src/rc_servo_frame_decoder.sv -----
// Top level of the servo receiver frame decoder.
//
// Takes one received serial byte per request and decodes frames of the form
// 0xA8, 0x00, channel count (CHANNELS), CHANNELS 16-bit values high byte
// first, one extra byte and a check byte. An 8-bit running sum covers every
// byte but the check byte; with accept_check_quirk set (reset value) a check
// byte of 0x0A is also accepted. A good frame yields CHANNELS result requests
// (status 0, channel_index from 1, raw value, position in tenths of percent,
// last on the final one); a bad frame yields one error request with status 1.
// Every byte up to and including a frame's check byte is taken as offered.
// On a good check byte in_ch.ready drops while results are produced; each
// channel runs the store read, the scale multiply, the reciprocal multiply,
// the correction multiply, the result load and the send, which waits out
// any output stall. A bad frame holds the input until its error request is
// sent. The user must write accept_check_quirk through cfg_wr_en /
// cfg_wr_data only while the block is idle; the block does not enforce it.
module rc_servo_frame_decoder #(
    parameter int CHANNELS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    rsfd_in_if.sink    in_ch,
    rsfd_out_if.source out_ch
);

    rsfd_pkg::dp_cmd_t    cmd;
    rsfd_pkg::dp_status_t status;

    // Sequence byte intake and the per-channel result steps
    rsfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Hold the frame state, channel values, scaling pipe and result register
    rsfd_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .rx_byte            (in_ch.rx_byte),
        .cmd                (cmd),
        .status             (status),
        .out_status         (out_ch.status),
        .out_channel_index  (out_ch.channel_index),
        .out_raw_value      (out_ch.raw_value),
        .out_percent_tenths (out_ch.percent_tenths),
        .out_last           (out_ch.last)
    );

endmodule

// ----- src/rsfd_checker.sv -----
// Port-level checks of the servo frame decoder, bound to the top level.
module rsfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        status,
    input logic [3:0]  channel_index,
    input logic [15:0] raw_value,
    input logic        last
);

    // A stalled result request holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(raw_value) && $stable(last))
    else $error("stalled result request changed");

    // Byte intake stops while results are pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
    else $error("input taken while result pending");

    // An error request is the only and final one of its frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> last && channel_index == 4'd0 && raw_value == 16'd0)
    else $error("malformed error result");

    // More results follow a non-final one before any new byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> !in_ready)
    else $error("frame results cut short");

endmodule

bind rc_servo_frame_decoder rsfd_checker u_rsfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .status        (out_ch.status),
    .channel_index (out_ch.channel_index),
    .raw_value     (out_ch.raw_value),
    .last          (out_ch.last)
);

// ----- verif/tb_rc_servo_frame_decoder.sv -----
// Self-checking testbench for the servo frame decoder: byte stream in, channel results out.
`timescale 1ns / 1ps

module tb_rc_servo_frame_decoder;

    localparam int CHANNELS    = 8;
    localparam int FIRST_DATA  = 3;
    localparam int EXTRA_POS   = FIRST_DATA + 2 * CHANNELS;
    localparam int CHECK_POS   = EXTRA_POS + 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 64;
    localparam int PHASE_BYTES = 38;

    localparam logic [7:0] SYNC_BYTE  = 8'hA8;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;
    localparam logic [7:0] COUNT_BYTE = 8'(CHANNELS);
    localparam logic [7:0] QUIRK_BYTE = 8'h0A;

    // Position scaling: round(3000 * (raw - 7172) / 9563) - 1500
    localparam longint SPAN_LO  = 7172;
    localparam longint SPAN_RAW = 9563;
    localparam longint SPAN_OUT = 3000;
    localparam longint PCT_BIAS = 1500;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum int {CHK_GOOD, CHK_QUIRK, CHK_BAD} check_kind_t;

    typedef struct packed {
        logic               status;
        logic [3:0]         channel_index;
        logic [15:0]        raw_value;
        logic signed [15:0] percent_tenths;
        logic               last;
    } servo_result_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    rsfd_in_if  in_ch ();
    rsfd_out_if out_ch ();

    rc_servo_frame_decoder #(
        .CHANNELS (CHANNELS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    // Bytes waiting to be offered, and results the decoder still owes us
    logic [7:0]    byte_backlog[$];
    servo_result_t expected_results[$];

    // Decoder state as predicted from the accepted byte stream
    logic [4:0]    frame_pos;
    logic [7:0]    byte_sum;
    logic [7:0]    hi_hold;
    logic [15:0]   chan_vals[CHANNELS];
    logic          quirk_en;

    // Channel values of the next frame to be built
    logic [15:0]   frame_vals[CHANNELS];

    idle_mode_t    idle_mode;
    int            error_count;
    int            cycle_count;
    int            bytes_queued;
    int            bytes_taken;
    int            results_seen;
    int            frames_passed;
    int            frames_failed;
    int            quirk_writes;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Round-to-nearest scaling; the exact half never occurs since the span is odd
    function automatic logic signed [15:0] tenths_of_percent(input logic [15:0] raw);
        longint twice;
        longint q;
        twice = 2 * (longint'(raw) - SPAN_LO) * SPAN_OUT + SPAN_RAW;
        q     = twice / (2 * SPAN_RAW);
        // Integer division truncates toward zero; pull negatives down to the floor
        if (twice < 0 && q * (2 * SPAN_RAW) != twice)
        begin
            q = q - 1;
        end
        return 16'(q - PCT_BIAS);
    endfunction

    // Advance the predicted decoder by one accepted byte and queue what it owes
    task automatic decode_byte(input logic [7:0] b);
        int            k;
        logic          ok;
        servo_result_t r;
        if (frame_pos == 0)
        begin
            // Hunting: only the start byte opens a frame
            if (b == SYNC_BYTE)
            begin
                byte_sum  = b;
                frame_pos = 5'd1;
            end
        end
        else if (frame_pos == 1 || frame_pos == 2)
        begin
            // Header: a mismatch drops back to hunting and consumes the byte
            if (b != ((frame_pos == 1) ? ZERO_BYTE : COUNT_BYTE))
            begin
                frame_pos = '0;
            end
            else
            begin
                byte_sum  = byte_sum + b;
                frame_pos = frame_pos + 5'd1;
            end
        end
        else if (frame_pos < CHECK_POS)
        begin
            // Channel bytes, high byte first; the extra byte is only summed
            if (frame_pos < EXTRA_POS)
            begin
                k = int'(frame_pos) - FIRST_DATA;
                if (k % 2 == 0)
                begin
                    hi_hold = b;
                end
                else
                begin
                    chan_vals[k / 2] = {hi_hold, b};
                end
            end
            byte_sum  = byte_sum + b;
            frame_pos = frame_pos + 5'd1;
        end
        else
        begin
            // Check byte: the frame ends here either way
            frame_pos = '0;
            ok = (byte_sum == b) || (quirk_en && b == QUIRK_BYTE);
            if (!ok)
            begin
                r = '{status: 1'b1, channel_index: '0, raw_value: '0,
                      percent_tenths: '0, last: 1'b1};
                expected_results.push_back(r);
                frames_failed++;
            end
            else
            begin
                for (k = 0; k < CHANNELS; k++)
                begin
                    r.status         = 1'b0;
                    r.channel_index  = 4'(k + 1);
                    r.raw_value      = chan_vals[k];
                    r.percent_tenths = tenths_of_percent(chan_vals[k]);
                    r.last           = (k == CHANNELS - 1);
                    expected_results.push_back(r);
                end
                frames_passed++;
            end
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        byte_backlog.push_back(b);
        bytes_queued++;
    endtask

    // Build a whole frame from frame_vals with the requested kind of check byte
    task automatic queue_frame(input check_kind_t kind);
        logic [7:0] sum;
        logic [7:0] extra;
        logic [7:0] chk;
        int         i;
        push_byte(SYNC_BYTE);
        push_byte(ZERO_BYTE);
        push_byte(COUNT_BYTE);
        sum = SYNC_BYTE + ZERO_BYTE + COUNT_BYTE;
        for (i = 0; i < CHANNELS; i++)
        begin
            push_byte(frame_vals[i][15:8]);
            push_byte(frame_vals[i][7:0]);
            sum = sum + frame_vals[i][15:8] + frame_vals[i][7:0];
        end
        extra = 8'($urandom);
        push_byte(extra);
        sum = sum + extra;
        case (kind)
            CHK_GOOD:  chk = sum;
            CHK_QUIRK: chk = QUIRK_BYTE;
            default:
            begin
                // Wrong sum that the quirk cannot rescue
                do
                begin
                    chk = sum + 8'($urandom_range(1, 255));
                end
                while (chk == QUIRK_BYTE);
            end
        endcase
        push_byte(chk);
    endtask

    // Channel value biased toward the ends of the field and the scaled span
    function automatic logic [15:0] pick_raw();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'(SPAN_LO);
            3:       return 16'(SPAN_LO + SPAN_RAW);
            4, 5, 6: return 16'($urandom_range(SPAN_LO, SPAN_LO + SPAN_RAW));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic hold_off(input logic sender_side);
        case (idle_mode)
            IDLE_SENDER:   return sender_side && ($urandom_range(0, 99) < 81);
            IDLE_RECEIVER: return !sender_side && ($urandom_range(0, 99) < 81);
            IDLE_BOTH:     return $urandom_range(0, 99) < 37;
            default:       return 1'b0;
        endcase
    endfunction

    // Driver: predict on each accepted request, then offer the next byte
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid   <= 1'b0;
            in_ch.rx_byte <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                decode_byte(in_ch.rx_byte);
                bytes_taken++;
            end
            // The slot is free once the current request is gone or was never there
            if (!in_ch.valid || in_ch.ready)
            begin
                if (byte_backlog.size() > 0 && !hold_off(1'b1))
                begin
                    in_ch.valid   <= 1'b1;
                    in_ch.rx_byte <= byte_backlog.pop_front();
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare every accepted result against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        servo_result_t want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected: status %0d channel %0d raw %0h",
                           out_ch.status, out_ch.channel_index, out_ch.raw_value);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, out_ch.status);
                        error_count++;
                    end
                    if (out_ch.channel_index !== want.channel_index)
                    begin
                        $error("channel_index: expected %0d, got %0d",
                               want.channel_index, out_ch.channel_index);
                        error_count++;
                    end
                    if (out_ch.raw_value !== want.raw_value)
                    begin
                        $error("raw_value: expected %0h, got %0h",
                               want.raw_value, out_ch.raw_value);
                        error_count++;
                    end
                    if (out_ch.percent_tenths !== want.percent_tenths)
                    begin
                        $error("percent_tenths: expected %0d, got %0d",
                               want.percent_tenths, out_ch.percent_tenths);
                        error_count++;
                    end
                    if (out_ch.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, out_ch.last);
                        error_count++;
                    end
                end
            end
            out_ch.ready <= !hold_off(1'b0);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, expected_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Hold until every byte is taken and every result has come back, then settle
    task automatic drain();
        while (byte_backlog.size() > 0 || in_ch.valid || expected_results.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write the quirk enable while the decoder is idle
    task automatic set_quirk(input logic v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        quirk_en     = v;
        quirk_writes++;
    endtask

    initial
    begin
        logic       phase_quirk[5];
        idle_mode_t phase_mode[5];
        int         p;
        int         start_count;
        int         i;
        int         pick;
        logic [7:0] b;

        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.rx_byte = '0;
        out_ch.ready  = 1'b0;
        frame_pos     = '0;
        byte_sum      = '0;
        hi_hold       = '0;
        quirk_en      = 1'b1;
        idle_mode     = IDLE_NONE;
        error_count   = 0;
        cycle_count   = 0;
        bytes_queued  = 0;
        bytes_taken   = 0;
        results_seen  = 0;
        frames_passed = 0;
        frames_failed = 0;
        quirk_writes  = 0;
        for (i = 0; i < CHANNELS; i++)
        begin
            chan_vals[i] = '0;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: stray bytes while hunting, each header break, a start byte
        // seen where 0x00 belongs, then good, bad and quirk-rescued frames
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h55);
        push_byte(SYNC_BYTE);
        push_byte(8'h55);
        push_byte(SYNC_BYTE);
        push_byte(SYNC_BYTE);
        push_byte(SYNC_BYTE);
        push_byte(ZERO_BYTE);
        push_byte(8'h07);
        frame_vals[0] = 16'h0000;
        frame_vals[1] = 16'hFFFF;
        frame_vals[2] = 16'(SPAN_LO);
        frame_vals[3] = 16'(SPAN_LO + SPAN_RAW);
        frame_vals[4] = 16'h00FF;
        frame_vals[5] = 16'hFF00;
        frame_vals[6] = {SYNC_BYTE, SYNC_BYTE};
        frame_vals[7] = 16'h5AA5;
        queue_frame(CHK_GOOD);
        for (i = 0; i < CHANNELS; i++)
        begin
            frame_vals[i] = pick_raw();
        end
        queue_frame(CHK_BAD);
        queue_frame(CHK_QUIRK);
        drain();

        // Random phases: alternate the quirk and sweep the idle patterns
        phase_quirk = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        phase_mode  = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_BOTH};
        for (p = 0; p < 5; p++)
        begin
            set_quirk(phase_quirk[p]);
            idle_mode   = phase_mode[p];
            start_count = bytes_queued;
            while (bytes_queued - start_count < PHASE_BYTES)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                begin
                    for (i = 0; i < CHANNELS; i++)
                    begin
                        frame_vals[i] = pick_raw();
                    end
                    if (pick < 55)
                    begin
                        queue_frame(CHK_GOOD);
                    end
                    else if (pick < 67)
                    begin
                        queue_frame(CHK_QUIRK);
                    end
                    else
                    begin
                        queue_frame(CHK_BAD);
                    end
                end
                else if (pick < 90)
                begin
                    // Broken header: wrong second byte or wrong channel count
                    push_byte(SYNC_BYTE);
                    if (pick < 85)
                    begin
                        do b = 8'($urandom); while (b == ZERO_BYTE);
                    end
                    else
                    begin
                        push_byte(ZERO_BYTE);
                        do b = 8'($urandom); while (b == COUNT_BYTE);
                    end
                    push_byte(b);
                end
                else
                begin
                    // Line noise between frames; keep it from opening a frame
                    repeat ($urandom_range(1, 3))
                    begin
                        do b = 8'($urandom); while (b == SYNC_BYTE);
                        push_byte(b);
                    end
                end
            end
            drain();
        end

        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            error_count++;
        end

        $display("Covered %0d bytes, %0d good and %0d rejected frames, %0d results checked,",
                 bytes_taken, frames_passed, frames_failed, results_seen);
        $display("%0d quirk enable writes across five idle and stall patterns.", quirk_writes);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- rc_servo_frame_decoder.f -----
src/rsfd_pkg.sv
src/rsfd_if.sv
src/rsfd_ctrl.sv
src/rsfd_datapath.sv
src/rc_servo_frame_decoder.sv
src/rsfd_checker.sv
verif/tb_rc_servo_frame_decoder.sv
